// File: src/nrmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Character codes, header text, fixed widths and the reciprocal constants
// shared by the parser front end and the conversion pipeline.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  // Saturated integer part of a coordinate (ddmm, up to 99999).
  localparam int INT_W   = 17;
  localparam int INT_SAT = 99999;

  // Output field widths.
  localparam int COORD_W = 31;
  localparam int MAG_W   = 30;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  localparam int HDR_LEN = 6;

  // Field positions after the header.
  localparam logic [2:0] FLD_PAST   = 3'd0;
  localparam logic [2:0] FLD_STATUS = 3'd3;
  localparam logic [2:0] FLD_LAT    = 3'd4;
  localparam logic [2:0] FLD_LAT_HS = 3'd5;
  localparam logic [2:0] FLD_LON    = 3'd6;
  localparam logic [2:0] FLD_LON_HS = 3'd7;

  // floor(x / 100) = (x * RECIP100) >> 24, exact for x below 2^17.
  localparam logic [17:0] RECIP100 = 18'd167773;
  // floor(y / 15) = (y * RECIP15) >> 29, exact for y below 2^25.
  localparam logic [25:0] RECIP15  = 26'd35791395;

  // Header text "$GNRMC", one character per match position.
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h4E;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic int pow10(input int n);
    int p;
    case (n)
      0:       p = 1;
      1:       p = 10;
      2:       p = 100;
      3:       p = 1000;
      4:       p = 10000;
      5:       p = 100000;
      6:       p = 1000000;
      default: p = 1;
    endcase
    return p;
  endfunction

endpackage

// File: src/nrmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC parser front end
// Hunts for the header, tracks fields and accumulates the coordinate digits
// one character per cycle while rec_ready is high; pushes a sentence record at each closing line feed.
// ----------------------------------------------------------------------------
module nrmc_front import nrmc_pkg::*; #(
  parameter int MAX_SENTENCE = 80,
  parameter int FRAC_DIGITS  = 4,
  parameter int FRAC_W       = 14,
  parameter int REC_W        = 4 + 2 * (INT_W + FRAC_W)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  output logic             rec_valid,
  input  logic             rec_ready,
  output logic [REC_W-1:0] rec
);

  logic              accept;
  logic [2:0]        hdr_pos;
  logic              in_sentence;
  logic [7:0]        sent_len;
  logic [2:0]        field_num;
  logic              first_char;
  logic              status_active;
  logic [INT_W-1:0]  lat_int, lon_int;
  logic [FRAC_W-1:0] lat_frac, lon_frac;
  logic              past_dot, scan_stop;
  logic [2:0]        frac_cnt;
  logic [1:0]        neg;

  // Shared number scanner for whichever coordinate field is open.
  logic [INT_W-1:0]  sel_int, scan_int_next;
  logic [FRAC_W-1:0] sel_frac, scan_frac_next;
  logic              past_dot_next, scan_stop_next;
  logic [2:0]        frac_cnt_next;
  logic [3:0]        digit;
  logic              is_digit;
  logic [19:0]       int_prod;
  logic              bad;
  logic              hemi_neg;

  assign in_ready = rec_ready;
  assign accept   = in_valid && in_ready;

  assign digit    = 4'(in_byte - CH_ZERO);
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign hemi_neg = (in_byte == CH_S) || (in_byte == CH_W);
  assign sel_int  = (field_num == FLD_LON) ? lon_int : lat_int;
  assign sel_frac = (field_num == FLD_LON) ? lon_frac : lat_frac;
  assign int_prod = 20'(sel_int) * 20'd10 + 20'(digit);

  always_comb begin
    scan_int_next  = sel_int;
    scan_frac_next = sel_frac;
    past_dot_next  = past_dot;
    scan_stop_next = scan_stop;
    frac_cnt_next  = frac_cnt;
    if (!scan_stop) begin
      if (in_byte == CH_DOT) begin
        if (past_dot) begin
          scan_stop_next = 1'b1;
        end else begin
          past_dot_next = 1'b1;
        end
      end else if (!is_digit) begin
        scan_stop_next = 1'b1;
      end else if (!past_dot) begin
        scan_int_next = (int_prod > 20'(INT_SAT)) ? INT_W'(INT_SAT) : int_prod[INT_W-1:0];
      end else if (frac_cnt < 3'(FRAC_DIGITS)) begin
        scan_frac_next = FRAC_W'(int'(sel_frac)
                         + int'(digit) * pow10(FRAC_DIGITS - 1 - int'(frac_cnt)));
        frac_cnt_next  = frac_cnt + 3'd1;
      end
    end
  end

  assign bad       = (sent_len < 8'd2) || (sent_len >= 8'(MAX_SENTENCE));
  assign rec_valid = accept && in_sentence && (in_byte == CH_LF);
  assign rec       = {neg, lon_frac, lon_int, lat_frac, lat_int, status_active, bad};

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos       <= '0;
      in_sentence   <= 1'b0;
      sent_len      <= '0;
      field_num     <= 3'd1;
      first_char    <= 1'b1;
      status_active <= 1'b0;
      lat_int       <= '0;
      lat_frac      <= '0;
      lon_int       <= '0;
      lon_frac      <= '0;
      past_dot      <= 1'b0;
      scan_stop     <= 1'b0;
      frac_cnt      <= '0;
      neg           <= 2'b01;
    end else if (accept) begin
      if (!in_sentence) begin
        if (in_byte == hdr_char(hdr_pos)) begin
          if (hdr_pos == 3'(HDR_LEN - 1)) begin
            // Full header seen: open a sentence with default field values.
            hdr_pos       <= '0;
            in_sentence   <= 1'b1;
            sent_len      <= 8'(HDR_LEN);
            field_num     <= 3'd1;
            first_char    <= 1'b1;
            status_active <= 1'b0;
            lat_int       <= '0;
            lat_frac      <= '0;
            lon_int       <= '0;
            lon_frac      <= '0;
            past_dot      <= 1'b0;
            scan_stop     <= 1'b0;
            frac_cnt      <= '0;
            neg           <= 2'b01;
          end else begin
            hdr_pos <= hdr_pos + 3'd1;
          end
        end else begin
          hdr_pos <= (in_byte == CH_DOLLAR) ? 3'd1 : 3'd0;
        end
      end else if (in_byte == CH_LF) begin
        in_sentence <= 1'b0;
        hdr_pos     <= '0;
      end else begin
        if (sent_len != 8'hFF) begin
          sent_len <= sent_len + 8'd1;
        end
        if (in_byte == CH_COMMA) begin
          if (field_num == FLD_LON_HS) begin
            field_num <= FLD_PAST;
          end else if (field_num != FLD_PAST) begin
            field_num <= field_num + 3'd1;
          end
          first_char <= 1'b1;
          past_dot   <= 1'b0;
          scan_stop  <= 1'b0;
          frac_cnt   <= '0;
        end else begin
          case (field_num)
            FLD_STATUS: begin
              if (first_char) begin
                status_active <= (in_byte == CH_A);
              end
            end
            FLD_LAT: begin
              lat_int   <= scan_int_next;
              lat_frac  <= scan_frac_next;
              past_dot  <= past_dot_next;
              scan_stop <= scan_stop_next;
              frac_cnt  <= frac_cnt_next;
            end
            FLD_LAT_HS: begin
              if (first_char) begin
                neg[0] <= hemi_neg;
              end
            end
            FLD_LON: begin
              lon_int   <= scan_int_next;
              lon_frac  <= scan_frac_next;
              past_dot  <= past_dot_next;
              scan_stop <= scan_stop_next;
              frac_cnt  <= frac_cnt_next;
            end
            FLD_LON_HS: begin
              if (first_char) begin
                neg[1] <= hemi_neg;
              end
            end
            default: begin
            end
          endcase
          first_char <= 1'b0;
        end
      end
    end
  end

endmodule

// File: src/nrmc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC record queue
// Small synchronous FIFO between the parser front end and the conversion
// pipeline.
// ----------------------------------------------------------------------------
module nrmc_fifo #(
  parameter int W     = 66,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign full     = (count == (PW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

// File: src/nrmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC conversion pipeline
// Turns a sentence record into signed microdegrees over four stages and an
// output register; the whole pipeline advances when the output can move.
// ----------------------------------------------------------------------------
module nrmc_back import nrmc_pkg::*; #(
  parameter int FRAC_DIGITS = 4,
  parameter int FRAC_W      = 14,
  parameter int REC_W       = 4 + 2 * (INT_W + FRAC_W)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rec_valid,
  output logic             rec_ready,
  input  logic [REC_W-1:0] rec,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      out_data
);

  logic              en;
  logic              v1, v2, v3, v4;
  logic              bad1, bad2, bad3, bad4;
  logic              stat1, stat2, stat3, stat4;
  logic [1:0]        neg1, neg2, neg3, neg4;

  logic [INT_W-1:0]  rin_int [2];
  logic [FRAC_W-1:0] rin_frac [2];
  logic [INT_W-1:0]  ip1 [2];
  logic [FRAC_W-1:0] fp1 [2], fp2 [2];
  logic [9:0]        deg1 [2], deg2 [2], deg3 [2], deg4 [2];
  logic [6:0]        rem2 [2];
  logic [24:0]       y3 [2];
  logic [20:0]       q4 [2];

  logic [34:0]       p100 [2];
  logic [16:0]       rdiff [2];
  logic [26:0]       m2 [2];
  logic [50:0]       p15 [2];
  logic [MAG_W-1:0]  mag [2];
  logic [COORD_W-1:0] coord [2];

  assign en        = !out_valid || out_ready;
  assign rec_ready = en;

  assign rin_int[0]  = rec[2 +: INT_W];
  assign rin_frac[0] = rec[2 + INT_W +: FRAC_W];
  assign rin_int[1]  = rec[2 + INT_W + FRAC_W +: INT_W];
  assign rin_frac[1] = rec[2 + 2*INT_W + FRAC_W +: FRAC_W];

  // Lane 0 is latitude, lane 1 longitude.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      p100[k]  = 35'(rin_int[k]) * 35'(RECIP100);
      rdiff[k] = 17'(ip1[k] - 17'(deg1[k]) * 17'd100);
      // minutes scaled to 10^-6 units, then (m2 + 30) / 60 as ((m2 + 30) >> 2) / 15
      m2[k]    = 27'(rem2[k]) * 27'd1000000
               + 27'(fp2[k]) * 27'(pow10(6 - FRAC_DIGITS));
      p15[k]   = 51'(y3[k]) * 51'(RECIP15);
      mag[k]   = 30'(deg4[k]) * 30'd1000000 + 30'(q4[k]);
      coord[k] = neg4[k] ? COORD_W'(-{1'b0, mag[k]}) : {1'b0, mag[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= rec_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad1  <= rec[0];
      stat1 <= rec[1];
      neg1  <= rec[REC_W-1 -: 2];
      bad2  <= bad1;
      stat2 <= stat1;
      neg2  <= neg1;
      bad3  <= bad2;
      stat3 <= stat2;
      neg3  <= neg2;
      bad4  <= bad3;
      stat4 <= stat3;
      neg4  <= neg3;
      for (int k = 0; k < 2; k++) begin
        ip1[k]  <= rin_int[k];
        fp1[k]  <= rin_frac[k];
        deg1[k] <= p100[k][33:24];
        deg2[k] <= deg1[k];
        rem2[k] <= rdiff[k][6:0];
        fp2[k]  <= fp1[k];
        deg3[k] <= deg2[k];
        y3[k]   <= 25'((m2[k] + 27'd30) >> 2);
        deg4[k] <= deg3[k];
        q4[k]   <= p15[k][49:29];
      end
      out_data <= bad4 ? 64'd1
                       : {coord[1], coord[0], stat4, 1'b0};
    end
  end

endmodule

// File: src/nmea_rmc_position_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC position parser
// Parses "$GNRMC" sentences from a byte stream into fix status and signed
// microdegree latitude and longitude, one result per line feed that closes a sentence.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the record queue is not full.
// A result is offered on m_tvalid after the line feed transfer passes the queue write,
//   then four conversion stages and the output register.
// s_tready drops only when four results wait behind a stalled output.
// Reset (rst, synchronous, active high) returns to header search and empties
//   the queue and the pipeline; ready again in the next cycle.
module nmea_rmc_position_parser_unit import nrmc_pkg::*; #(
  parameter int MAX_SENTENCE = 80,
  parameter int FRAC_DIGITS  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [0] sentence_status, [1] fix_valid,
                                 // [32:2] latitude_microdeg, [63:33] longitude_microdeg
);

  // The fraction register holds up to FRAC_DIGITS decimal digits.
  localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS);
  // Sentence record: length error, status, lat int/frac, lon int/frac, signs.
  localparam int REC_W  = 4 + 2 * (INT_W + FRAC_W);
  localparam int QDEPTH = 4;

  logic             push, full, empty, pop;
  logic [REC_W-1:0] push_rec, pop_rec;

  // The front end parses every character as it is transferred in; it only
  // waits when the record queue is full.
  nrmc_front #(
    .MAX_SENTENCE (MAX_SENTENCE),
    .FRAC_DIGITS  (FRAC_DIGITS),
    .FRAC_W       (FRAC_W),
    .REC_W        (REC_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .rec_valid (push),
    .rec_ready (!full),
    .rec       (push_rec)
  );

  // Finished sentences queue here so a stalled output does not hold up the
  // character stream.
  nrmc_fifo #(
    .W     (REC_W),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_rec),
    .empty     (empty)
  );

  // The back end converts ddmm.mmmm to microdegrees with reciprocal
  // multiplies in place of the divisions by 100 and by 60.
  nrmc_back #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .FRAC_W      (FRAC_W),
    .REC_W       (REC_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (!empty),
    .rec_ready (pop),
    .rec       (pop_rec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// File: src/nrmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC parser port checker
// Watches the stream ports of the parser for result and reset behavior.
// ----------------------------------------------------------------------------
module nrmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A length error carries no fix and zero coordinates.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[63:1] == 63'd0)
    else $error("length error result carries data");

  // Latitude stays within the range of a saturated ddmm.mmmm value.
  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[32:2]) <= 31'sd1002000000)
              && ($signed(m_tdata[32:2]) >= -31'sd1002000000))
    else $error("latitude out of range");

  // Reset empties the pipeline and the queue.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("state left after reset");

endmodule

bind nmea_rmc_position_parser_unit nrmc_checker u_nrmc_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC position parser testbench
// Streams directed and random character traffic into the parser, predicts
// every report from its own model of the sentence scanner, and checks each
// report field by field under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
  import nrmc_pkg::*;

  localparam int     MAX_SENTENCE = 80;
  localparam int     FRAC_DIGITS  = 4;
  localparam longint FRAC_SCALE   = 10 ** FRAC_DIGITS;
  localparam int     RX_ITEMS     = 1450;
  localparam int     LONG_HOLD    = 2000;
  localparam int     IDLE_LIMIT   = 20000;

  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_HIGH  = 8'hFF;
  localparam logic [47:0] HDR_TEXT = "$GNRMC";

  // One report as it leaves the block, packed like m_tdata.
  typedef struct packed {
    logic [30:0] lon_udeg;
    logic [30:0] lat_udeg;
    logic        fix_valid;
    logic        len_err;
  } rmc_fix_t;

  // One character to send; drain_first holds it back until all reports are in.
  typedef struct packed {
    logic       drain_first;
    logic [7:0] ch;
  } rx_item_t;

  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  rx_item_t rx_char_q[$];
  rmc_fix_t fix_report_q[$];
  bit       drain_next = 1'b0;
  int       err_cnt = 0;

  nmea_rmc_position_parser_unit #(
    .MAX_SENTENCE(MAX_SENTENCE),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // --------------------------------------------------------------------------
  // Sentence scanner model. Index 0 of the coordinate arrays is latitude,
  // index 1 is longitude.
  // --------------------------------------------------------------------------
  logic [2:0]  hdr_pos;
  bit          in_sent;
  logic [7:0]  sent_len;
  logic [2:0]  fld_num;
  bit          fld_first;
  bit          stat_a;
  logic [16:0] coord_int [0:1];
  logic [13:0] coord_frac [0:1];
  bit          past_dot;
  bit          scan_stop;
  logic [2:0]  frac_cnt;
  bit   [1:0]  hemi_neg;

  // A header match reloads all per-sentence state; latitude defaults to south.
  function automatic void open_sentence();
    in_sent       = 1'b1;
    hdr_pos       = 3'd0;
    sent_len      = 8'd6;
    fld_num       = 3'd1;
    fld_first     = 1'b1;
    stat_a        = 1'b0;
    coord_int[0]  = '0;
    coord_int[1]  = '0;
    coord_frac[0] = '0;
    coord_frac[1] = '0;
    past_dot      = 1'b0;
    scan_stop     = 1'b0;
    frac_cnt      = 3'd0;
    hemi_neg      = 2'b01;
  endfunction

  function automatic void clear_parser();
    open_sentence();
    in_sent  = 1'b0;
    sent_len = 8'd0;
  endfunction

  // Digits and one dot are taken; anything else freezes the field value.
  function automatic void scan_coord(input int idx, input logic [7:0] c);
    int unsigned acc;
    int unsigned wt;
    if (scan_stop) return;
    if (c == CH_DOT) begin
      if (past_dot) scan_stop = 1'b1;
      else past_dot = 1'b1;
    end else if (c < CH_ZERO || c > CH_NINE) begin
      scan_stop = 1'b1;
    end else if (!past_dot) begin
      acc = coord_int[idx] * 10 + (c - CH_ZERO);
      coord_int[idx] = (acc > INT_SAT) ? 17'(INT_SAT) : 17'(acc);
    end else if (frac_cnt < FRAC_DIGITS) begin
      wt = FRAC_SCALE;
      for (int k = 0; k <= frac_cnt; k++) wt = wt / 10;
      coord_frac[idx] = 14'(coord_frac[idx] + (c - CH_ZERO) * wt);
      frac_cnt++;
    end
  endfunction

  // ddmm.mmmm to signed microdegrees, minutes rounded half up.
  function automatic logic [30:0] to_udeg(input logic [16:0] ip, input logic [13:0] fp,
                                          input bit neg);
    longint deg;
    longint mins;
    longint part;
    longint mag;
    deg  = longint'(ip) / 100;
    mins = (longint'(ip) % 100) * FRAC_SCALE + longint'(fp);
    part = (mins * 1000000 + 30 * FRAC_SCALE) / (60 * FRAC_SCALE);
    mag  = deg * 1000000 + part;
    if (neg) mag = -mag;
    return mag[30:0];
  endfunction

  // Advances the model by one transferred character and queues any report.
  function automatic void parse_char(input logic [7:0] c);
    rmc_fix_t r;
    bit       bad;
    if (!in_sent) begin
      if (hdr_pos < HDR_LEN && c == HDR_TEXT[8 * (HDR_LEN - 1 - int'(hdr_pos)) +: 8])
        hdr_pos++;
      else
        hdr_pos = (c == CH_DOLLAR) ? 3'd1 : 3'd0;
      if (hdr_pos >= HDR_LEN) open_sentence();
      return;
    end
    if (c == CH_LF) begin
      bad         = (sent_len < 2) || (sent_len >= MAX_SENTENCE);
      r.len_err   = bad;
      r.fix_valid = !bad && stat_a;
      r.lat_udeg  = bad ? '0 : to_udeg(coord_int[0], coord_frac[0], hemi_neg[0]);
      r.lon_udeg  = bad ? '0 : to_udeg(coord_int[1], coord_frac[1], hemi_neg[1]);
      fix_report_q.push_back(r);
      in_sent = 1'b0;
      hdr_pos = 3'd0;
      return;
    end
    if (sent_len != 8'hFF) sent_len++;
    if (c == CH_COMMA) begin
      if (fld_num == FLD_LON_HS) fld_num = FLD_PAST;
      else if (fld_num != FLD_PAST) fld_num++;
      fld_first = 1'b1;
      past_dot  = 1'b0;
      scan_stop = 1'b0;
      frac_cnt  = 3'd0;
      return;
    end
    case (fld_num)
      FLD_STATUS: if (fld_first) stat_a = (c == CH_A);
      FLD_LAT:    scan_coord(0, c);
      FLD_LAT_HS: if (fld_first) hemi_neg[0] = (c == CH_S || c == CH_W);
      FLD_LON:    scan_coord(1, c);
      FLD_LON_HS: if (fld_first) hemi_neg[1] = (c == CH_S || c == CH_W);
      default: ;
    endcase
    fld_first = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction.
  // --------------------------------------------------------------------------
  function automatic void push_ch(input logic [7:0] c);
    rx_char_q.push_back(rx_item_t'{drain_next, c});
    drain_next = 1'b0;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endfunction

  function automatic void push_digits(input int n);
    for (int i = 0; i < n; i++) push_ch(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 5))
      0: return "-";
      1: return "+";
      2: return " ";
      3: return CH_DOT;
      4: return "x";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly plain ddmm.mmmm with random digit counts, now and then an
  // overlong integer part or a stray character that stops the scan.
  function automatic void push_coord();
    int n_int;
    int n_frac;
    int junk_at;
    bit dot;
    n_int   = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
    dot     = ($urandom_range(0, 4) != 0);
    n_frac  = dot ? $urandom_range(0, 6) : 0;
    junk_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_int + n_frac) : -1;
    for (int i = 0; i < n_int; i++) begin
      if (i == junk_at) push_ch(junk_char());
      push_digits(1);
    end
    if (dot) push_ch(CH_DOT);
    for (int i = 0; i < n_frac; i++) begin
      if (n_int + i == junk_at) push_ch(junk_char());
      push_digits(1);
    end
    if (junk_at == n_int + n_frac) push_ch(junk_char());
  endfunction

  function automatic void push_hemi();
    case ($urandom_range(0, 7))
      0: push_text("N");
      1: push_text("S");
      2: push_text("E");
      3: push_text("W");
      4: ;
      5: push_text("SW");
      6: push_ch(8'($urandom_range(0, 255)));
      default: push_text("N");
    endcase
  endfunction

  function automatic void push_random_sentence();
    int cut;
    int n_extra;
    int n_pad;
    if ($urandom_range(0, 3) == 0)
      for (int i = 0; i < $urandom_range(1, 4); i++) push_ch(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 15))
      0: push_text("$GPRMC");
      1: push_text("$GNRM");
      2: push_text("$$GNRMC");
      3: push_text("$GNRMC$");
      default: push_text("$GNRMC");
    endcase
    cut     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : 99;
    n_extra = $urandom_range(0, 5);
    for (int f = 1; f <= 7 + n_extra && f <= cut; f++) begin
      push_ch(CH_COMMA);
      case (f)
        1: push_digits($urandom_range(0, 6));
        2: if ($urandom_range(0, 1)) push_text("A");
        3: case ($urandom_range(0, 5))
             0: push_text("V");
             1: ;
             2: push_text("AV");
             3: push_ch(8'($urandom_range(0, 255)));
             default: push_text("A");
           endcase
        4, 6: push_coord();
        5, 7: push_hemi();
        default: push_digits($urandom_range(0, 4));
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      n_pad = $urandom_range(40, 270);
      for (int i = 0; i < n_pad; i++) push_ch(8'($urandom_range(8'h20, 8'h7E)));
    end
    if ($urandom_range(0, 1)) push_text("*5C");
    if ($urandom_range(0, 1)) push_ch(CH_CR);
    push_ch(CH_LF);
  endfunction

  // Pads a valid sentence with filler so that its length is exactly total_len.
  function automatic void push_padded(input int total_len);
    string body;
    body = "$GNRMC,,,A,4530.0000,S,07300.5000,W,";
    push_text(body);
    for (int i = body.len(); i < total_len; i++) push_ch("Z");
    push_ch(CH_LF);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, stimulus, reset and the end of the run.
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    int n_sent;
    clear_parser();

    // Directed traffic: a full sentence, empty fields, field extremes,
    // scan stops, odd hemisphere letters, header restarts, control bytes
    // inside a sentence, and lengths around the limit and past saturation.
    push_text("$GNRMC,123519,A,4807.0380,N,01131.0000,E,022.4,084.4,230394,003.1,W*6A");
    push_ch(CH_CR);
    push_ch(CH_LF);
    push_text("$GNRMC,,,,,,,\n");
    push_text("$GNRMC\n");
    push_text("$GNRMC,0,0,V,3412.5,,11805.25,\n");
    push_text("$GNRMC,1,2,A,9959.9999,S,17959.9999,W,x,y\n");
    push_text("$GNRMC,,,A,0000.0000,N,00000.0000,E\n");
    push_text("$GNRMC,,,A,12345678.123456,N,99999.99999,E\n");
    push_text("$GNRMC,,,A,12.3.4,N,-45,W\n");
    push_text("$GNRMC,,,A, 12,Nope,4x5.6,SW\n");
    push_text("$GNRMC,,,A,5000,W,6000,S,S,W,,,,,,,1234,A\n");
    push_text("$GNRMC,,,VA,1,N,2,E\n");
    push_ch(CH_LF);
    push_ch(CH_NUL);
    push_ch(CH_HIGH);
    push_text("$G$GNRMC,,,A,1,N,1,E\n");
    push_text("$GPRMC,,,A,1,N\n");
    push_text("$GNRM$GNRMC,,,A,2,N,3,W\n");
    push_text("$GNRMC,$,");
    push_ch(CH_NUL);
    push_text(",A");
    push_ch(CH_HIGH);
    push_text(",1234.5");
    push_ch(CH_CR);
    push_text(",N,7\n");
    push_padded(MAX_SENTENCE - 1);
    push_padded(MAX_SENTENCE);
    push_padded(300);

    // Random part: mostly well-formed sentences with random content that top
    // the stream up to RX_ITEMS characters. Two of them wait until every
    // report outstanding has come back.
    n_sent = 0;
    while (rx_char_q.size() < RX_ITEMS || n_sent < 8) begin
      if (n_sent == 2 || n_sent == 6) drain_next = 1'b1;
      push_random_sentence();
      n_sent++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (rx_char_q.size() != 0 || s_tvalid) @(posedge clk);
    while (fix_report_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Source: bursts of random length separated by random gaps. A character is
  // held until its transfer; the model sees it on that same edge.
  // --------------------------------------------------------------------------
  int       burst_left = 0;
  int       gap_left = 0;
  rx_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) parse_char(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (rx_char_q.size() != 0 &&
                     !(rx_char_q[0].drain_first && fix_report_q.size() != 0)) begin
          next_item = rx_char_q.pop_front();
          s_tdata   <= next_item.ch;
          s_tvalid  <= 1'b1;
          burst_left--;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: checks each report transfer against the oldest prediction, and
  // drives m_tready from a pattern that changes mode every so often. Once,
  // early on, it holds off for a long stretch so the block backs up.
  // --------------------------------------------------------------------------
  int          fix_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mode_left = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;
  rmc_fix_t    got;
  rmc_fix_t    want;

  function automatic void check_field(input string name, input logic [30:0] exp_v,
                                      input logic [30:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(exp_v), $signed(act_v));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        fix_seen++;
        if (fix_report_q.size() == 0) begin
          err_cnt++;
          $display("%0t: report with none expected, expected nothing, got %h", $time, m_tdata);
        end else begin
          want = fix_report_q.pop_front();
          check_field("sentence_status", 31'(want.len_err), 31'(got.len_err));
          check_field("fix_valid", 31'(want.fix_valid), 31'(got.fix_valid));
          check_field("latitude_microdeg", want.lat_udeg, got.lat_udeg);
          check_field("longitude_microdeg", want.lon_udeg, got.lon_udeg);
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && fix_seen >= 3) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (ready_mode)
          RDY_ALWAYS: m_tready <= 1'b1;
          RDY_HALF:   m_tready <= ($urandom_range(0, 1) == 0);
          RDY_SPARSE: m_tready <= ($urandom_range(0, 9) < 2);
          default:    m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when neither side has transferred for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
